// File: sv/crc8fc_pkg.sv
// Types, constants and the CRC-8 fold shared by the frame checker modules.
// No dependencies.
package crc8fc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SIZE_W      = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_PATTERN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_VALUE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_FLOOR     = 2'd2;

    localparam logic [15:0]       HEADER_RESET   = 16'hAA55;
    localparam logic [7:0]        TAIL_RESET     = 8'h0D;
    localparam logic [SIZE_W-1:0] MIN_SIZE_RESET = 9'd7;

    localparam logic [SIZE_W-1:0] SIZE_CAP = 9'd511;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_HEADER = 3'd2;
    localparam logic [2:0] ST_TAIL   = 3'd3;
    localparam logic [2:0] ST_LENGTH = 3'd4;
    localparam logic [2:0] ST_CRC    = 3'd5;

    typedef struct packed {
        logic [15:0]       header_pattern;
        logic [7:0]        tail_value;
        logic [SIZE_W-1:0] size_floor;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic              frame_ok;
        logic [2:0]        status;
        logic [SIZE_W-1:0] frame_size;
    } result_t;

    // MSB-first CRC-8 over one byte, no reflection
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_MSB) != 8'h00)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

// File: sv/crc8fc_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
// Depends on crc8fc_pkg for widths.
interface crc8fc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_frame;

    modport source (output valid, output data_byte, output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface crc8fc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          frame_ok;
    logic [2:0]                    status;
    logic [crc8fc_pkg::SIZE_W-1:0] frame_size;

    modport source (output valid, output frame_ok, output status, output frame_size,
                    input ready);
    modport sink   (input valid, input frame_ok, input status, input frame_size,
                    output ready);
endinterface

// File: sv/crc8fc_cfg_regs.sv
// Configuration registers of the frame checker, written through a plain write port.
// Depends on crc8fc_pkg.
module crc8fc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [crc8fc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crc8fc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output crc8fc_pkg::cfg_t                   cfg
);

    crc8fc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_pattern <= crc8fc_pkg::HEADER_RESET;
            cfg_reg.tail_value     <= crc8fc_pkg::TAIL_RESET;
            cfg_reg.size_floor     <= crc8fc_pkg::MIN_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                crc8fc_pkg::REG_HEADER_PATTERN:
                    cfg_reg.header_pattern <= cfg_wdata;
                crc8fc_pkg::REG_TAIL_VALUE:
                    cfg_reg.tail_value <= cfg_wdata[7:0];
                crc8fc_pkg::REG_SIZE_FLOOR:
                    cfg_reg.size_floor <= cfg_wdata[crc8fc_pkg::SIZE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/crc8fc_in_stage.sv
// Input register: holds one received byte until the frame tracker takes it.
// Depends on crc8fc_pkg.
module crc8fc_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  crc8fc_pkg::in_item_t in_item,
    output logic                 in_ready,
    input  logic                 advance,
    output logic                 held_valid,
    output crc8fc_pkg::in_item_t held_item
);

    logic                 valid_reg;
    logic                 valid_next;
    crc8fc_pkg::in_item_t item_reg;

    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
            valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_item;
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// File: sv/crc8fc_frame_track.sv
// Per-frame state (position, header match, length, running CRC, last two bytes)
// and the end-of-frame checks. Depends on crc8fc_pkg.
module crc8fc_frame_track (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crc8fc_pkg::cfg_t     cfg,
    input  logic                 step,
    input  crc8fc_pkg::in_item_t item,
    output crc8fc_pkg::result_t  result
);

    localparam int W = crc8fc_pkg::SIZE_W;

    logic [W-1:0] pos_reg,    pos_next;
    logic         hdr_reg,    hdr_next;
    logic [7:0]   len_reg,    len_next;
    logic [7:0]   crc_reg,    crc_next;
    logic [7:0]   d0_reg,     d0_next;
    logic [7:0]   d1_reg,     d1_next;

    logic         hdr_cur;
    logic [7:0]   len_cur;
    logic [7:0]   crc_cur;
    logic [W-1:0] size;
    logic [W:0]   expect_size;
    logic [2:0]   status;
    logic [7:0]   b;

    assign b = item.data_byte;

    always_comb
    begin
        hdr_cur = hdr_reg;
        if (pos_reg == W'(0) && b != cfg.header_pattern[15:8])
            hdr_cur = 1'b0;
        if (pos_reg == W'(1) && b != cfg.header_pattern[7:0])
            hdr_cur = 1'b0;
        len_cur = (pos_reg == W'(2)) ? b : len_reg;
        // byte two places back can no longer be the CRC or the tail
        crc_cur = (pos_reg >= W'(4)) ? crc8fc_pkg::crc_fold(crc_reg, d1_reg) : crc_reg;
        size    = (pos_reg < crc8fc_pkg::SIZE_CAP) ? pos_reg + W'(1) : crc8fc_pkg::SIZE_CAP;
        expect_size = {1'b0, {(W-8){1'b0}}, len_cur} + (W+1)'(2);

        if (size < cfg.size_floor)
            status = crc8fc_pkg::ST_SHORT;
        else if (size < W'(2) || !hdr_cur)
            status = crc8fc_pkg::ST_HEADER;
        else if (b != cfg.tail_value)
            status = crc8fc_pkg::ST_TAIL;
        else if (size < W'(3) || len_cur < 8'd2 || {1'b0, size} != expect_size)
            status = crc8fc_pkg::ST_LENGTH;
        else if (crc_cur != d0_reg)
            status = crc8fc_pkg::ST_CRC;
        else
            status = crc8fc_pkg::ST_OK;
    end

    always_comb
    begin
        pos_next = pos_reg;
        hdr_next = hdr_reg;
        len_next = len_reg;
        crc_next = crc_reg;
        d0_next  = d0_reg;
        d1_next  = d1_reg;
        if (step)
        begin
            if (item.end_of_frame)
            begin
                pos_next = '0;
                hdr_next = 1'b1;
                len_next = 8'h00;
                crc_next = crc8fc_pkg::CRC_INIT;
                d0_next  = 8'h00;
                d1_next  = 8'h00;
            end
            else
            begin
                pos_next = size;
                hdr_next = hdr_cur;
                len_next = len_cur;
                crc_next = crc_cur;
                d0_next  = b;
                d1_next  = d0_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hdr_reg <= 1'b1;
            len_reg <= 8'h00;
            crc_reg <= crc8fc_pkg::CRC_INIT;
            d0_reg  <= 8'h00;
            d1_reg  <= 8'h00;
        end
        else
        begin
            pos_reg <= pos_next;
            hdr_reg <= hdr_next;
            len_reg <= len_next;
            crc_reg <= crc_next;
            d0_reg  <= d0_next;
            d1_reg  <= d1_next;
        end
    end

    assign result.frame_ok   = (status == crc8fc_pkg::ST_OK);
    assign result.status     = status;
    assign result.frame_size = size;

endmodule

// File: sv/crc8fc_out_stage.sv
// Result register: holds one frame report until the consumer takes it.
// Depends on crc8fc_pkg.
module crc8fc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  crc8fc_pkg::result_t load_result,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output crc8fc_pkg::result_t out_result
);

    logic                valid_reg;
    logic                valid_next;
    crc8fc_pkg::result_t result_reg;

    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= load_result;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// File: sv/crc8_frame_checker.sv
// Top level of the CRC-8 frame checker: config registers, input register,
// frame tracker and result register. Depends on crc8fc_pkg and crc8fc_if.
//
// Takes one received byte per clock and gives one report per frame on the
// byte flagged end_of_frame. A byte is held in the input register, then the
// frame tracker folds the CRC (polynomial 0x07, MSB first) and runs the checks
// combinationally, and the report is loaded into the result register when it has space.
// A new byte is accepted in every cycle as long as the result register is empty or
// being drained; only a waiting report in front of another end-of-frame byte holds
// off the input. The user must write configuration with cfg_we/cfg_index/cfg_wdata
// while no frame is in flight (not enforced by the block); index 3 is ignored.
module crc8_frame_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [crc8fc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crc8fc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    crc8fc_byte_if.sink                        frame_bytes,
    crc8fc_result_if.source                    results
);

    crc8fc_pkg::cfg_t     cfg;
    crc8fc_pkg::in_item_t in_item;
    crc8fc_pkg::in_item_t held_item;
    crc8fc_pkg::result_t  track_result;
    crc8fc_pkg::result_t  out_result;
    logic                 held_valid;
    logic                 advance;
    logic                 out_space;

    assign in_item.data_byte    = frame_bytes.data_byte;
    assign in_item.end_of_frame = frame_bytes.end_of_frame;

    assign advance = held_valid && (!held_item.end_of_frame || out_space);

    crc8fc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    crc8fc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (frame_bytes.valid),
        .in_item    (in_item),
        .in_ready   (frame_bytes.ready),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    crc8fc_frame_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (held_item),
        .result (track_result)
    );

    crc8fc_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && held_item.end_of_frame),
        .load_result (track_result),
        .space       (out_space),
        .out_valid   (results.valid),
        .out_ready   (results.ready),
        .out_result  (out_result)
    );

    assign results.frame_ok   = out_result.frame_ok;
    assign results.status     = out_result.status;
    assign results.frame_size = out_result.frame_size;

endmodule

// File: sv/crc8fc_checker.sv
// Port-level checks on the frame checker's result channel, bound to the top level.
// Depends on crc8fc_pkg and crc8_frame_checker.
module crc8fc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          frame_ok,
    input logic [2:0]                    status,
    input logic [crc8fc_pkg::SIZE_W-1:0] frame_size
);

    a_ok_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_ok == (status == crc8fc_pkg::ST_OK)))
        else $error("frame_ok disagrees with status");

    a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == crc8fc_pkg::ST_OK || status == crc8fc_pkg::ST_SHORT ||
                       status == crc8fc_pkg::ST_HEADER || status == crc8fc_pkg::ST_TAIL ||
                       status == crc8fc_pkg::ST_LENGTH || status == crc8fc_pkg::ST_CRC))
        else $error("status code out of range");

    // a passing frame has header, length >= 2, CRC and tail
    a_ok_min_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_ok) |-> (frame_size >= crc8fc_pkg::SIZE_W'(4)))
        else $error("passing frame too small");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(status) && $stable(frame_size)))
        else $error("stalled request changed");

endmodule

bind crc8_frame_checker crc8fc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .frame_ok   (results.frame_ok),
    .status     (results.status),
    .frame_size (results.frame_size)
);
